FILE: rtl/positional_list_engine_macros.svh
// Assertion macros for the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define PLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLE_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/ple_pkg.sv
// Package with types, widths and codes shared by the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;

  localparam int CAPACITY = 64;

  localparam int ACT_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 7;
  localparam int ST_W  = 3;
  localparam int FI_W  = 6;
  localparam int EC_W  = 7;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SEARCH  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READOUT = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        item_position;
  } item_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] out_value;
    logic [FI_W-1:0]         found_index;
    logic [EC_W-1:0]         entry_count;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } ple_stat_t;

endpackage

FILE: rtl/ple_mem.sv
// Entry store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
module ple_mem
  import ple_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: rtl/ple_seq.sv
// Sequencer: walks the store an entry a cycle for shift, search, unstalled readout.
`timescale 1ns / 1ps
module ple_seq
  import ple_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_take,
  input  item_t            item,
  input  logic             out_free,
  input  logic [VAL_W-1:0] rdata,
  output mem_req_t         mem_req,
  output logic             res_load,
  output result_t          res,
  output ple_stat_t        stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_INS_SHIFT, S_INS_PUT, S_DEL_GET, S_DEL_SHIFT,
    S_SRCH, S_RDOUT, S_RESP
  } state_t;

  state_t           state;
  logic [ACT_W-1:0] act;
  logic [VAL_W-1:0] val;
  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] count;
  logic [ST_W-1:0]  res_status;
  logic [VAL_W-1:0] res_value;
  logic [IDX_W-1:0] res_index;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CNT_W-1:0] idx_cnt;
  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W-1:0] idx_p2;
  logic             full;
  logic             empty;
  logic             at_pos;
  logic             match;
  logic             rd_last;

  assign pos_ext = CMP_W'(pos);
  assign cnt_ext = CMP_W'(count);
  assign idx_cnt = CNT_W'(idx);
  assign idx_p1  = idx_cnt + CNT_W'(1);
  assign idx_p2  = idx_cnt + CNT_W'(2);
  assign full    = (count >= CNT_W'(CAPACITY));
  assign empty   = (count == '0);
  assign at_pos  = (CMP_W'(idx) == pos_ext);
  assign match   = (rdata == val);
  assign rd_last = (idx_p1 == count);

  assign stat.idle  = (state == S_IDLE);
  assign stat.count = count;

  always_comb begin
    mem_req  = '0;
    res_load = 1'b0;
    res      = '0;
    res.entry_count = EC_W'(count);
    case (state)
      S_DISPATCH: begin
        case (act)
          ACT_INSERT: begin
            if (!full && !(pos_ext > cnt_ext)) begin
              if (pos_ext == cnt_ext) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = IDX_W'(pos);
                mem_req.wdata = val;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = IDX_W'(count - CNT_W'(1));
              end
            end
          end
          ACT_DELETE: begin
            if (!empty && (pos_ext < cnt_ext)) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = IDX_W'(pos);
            end
          end
          ACT_SEARCH, ACT_READOUT: begin
            if (!empty) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = '0;
            end
          end
          default: begin
          end
        endcase
      end
      S_INS_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = IDX_W'(idx_p1);
        mem_req.wdata = rdata;
        if (!at_pos) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx - IDX_W'(1);
        end
      end
      S_INS_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = IDX_W'(pos);
        mem_req.wdata = val;
      end
      S_DEL_GET: begin
        if (!rd_last) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = IDX_W'(idx_p1);
        end
      end
      S_DEL_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx;
        mem_req.wdata = rdata;
        if (idx_p2 != count) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = IDX_W'(idx_p2);
        end
      end
      S_SRCH: begin
        if (!match && !rd_last) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = IDX_W'(idx_p1);
        end
      end
      S_RDOUT: begin
        if (out_free) begin
          res_load      = 1'b1;
          res.status    = ST_OK;
          res.out_value = rdata;
          res.last      = rd_last;
          if (!rd_last) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = IDX_W'(idx_p1);
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          res_load        = 1'b1;
          res.status      = res_status;
          res.out_value   = res_value;
          res.found_index = FI_W'(res_index);
          res.last        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_take) begin
            act   <= item.action;
            val   <= item.item_value;
            pos   <= item.item_position;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_status <= ST_OK;
          res_value  <= '0;
          res_index  <= '0;
          state      <= S_RESP;
          case (act)
            ACT_CLEAR: begin
              count <= '0;
            end
            ACT_INSERT: begin
              if (full) begin
                res_status <= ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                res_status <= ST_BADPOS;
              end else if (pos_ext == cnt_ext) begin
                count <= count + CNT_W'(1);
              end else begin
                idx   <= IDX_W'(count - CNT_W'(1));
                state <= S_INS_SHIFT;
              end
            end
            ACT_DELETE: begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                res_status <= ST_BADPOS;
              end else begin
                idx   <= IDX_W'(pos);
                state <= S_DEL_GET;
              end
            end
            ACT_SEARCH: begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else begin
                idx   <= '0;
                state <= S_SRCH;
              end
            end
            ACT_READOUT: begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else begin
                idx   <= '0;
                state <= S_RDOUT;
              end
            end
            default: begin
            end
          endcase
        end
        S_INS_SHIFT: begin
          if (at_pos) begin
            state <= S_INS_PUT;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_INS_PUT: begin
          count <= count + CNT_W'(1);
          state <= S_RESP;
        end
        S_DEL_GET: begin
          res_value <= rdata;
          if (rd_last) begin
            count <= count - CNT_W'(1);
            state <= S_RESP;
          end else begin
            state <= S_DEL_SHIFT;
          end
        end
        S_DEL_SHIFT: begin
          if (idx_p2 == count) begin
            count <= count - CNT_W'(1);
            state <= S_RESP;
          end else begin
            idx <= IDX_W'(idx_p1);
          end
        end
        S_SRCH: begin
          if (match) begin
            res_index <= idx;
            state     <= S_RESP;
          end else if (rd_last) begin
            res_status <= ST_NOTFOUND;
            state      <= S_RESP;
          end else begin
            idx <= IDX_W'(idx_p1);
          end
        end
        S_RDOUT: begin
          if (out_free) begin
            if (rd_last) begin
              state <= S_IDLE;
            end else begin
              idx <= IDX_W'(idx_p1);
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/positional_list_engine.sv
// Top level of the positional list engine: sequencer, entry store and result register.
//
// Usage: one item beat carries an action (clear, insert, delete, search, readout),
// a value and a position. Every item gives one result beat with last set, except
// readout of a non-empty list, which gives one beat per entry in order, last on
// the final one. Both channels use valid/ready.
// The block takes one item at a time; item_ready is high only while it is idle.
// From item acceptance the sequencer passes a dispatch state that makes the checks,
// then goes to the response state for clear, failed checks and insert at the end;
// insert elsewhere first moves the entries from the last down to pos up one place,
// delete reads the entry at pos and moves the later entries down one place, and
// search reads from the front to a match or the end. Readout gives one entry per
// cycle unless the receiver stalls. The entry store's read data is registered.
// A result register sits at the output, so the next item can be accepted while
// the previous result waits. When the receiver stalls, the sequencer holds its
// place and resumes with no beat lost. Synchronous reset empties the list and
// drops any pending result; stored entries are not cleared.
`timescale 1ns / 1ps
`include "positional_list_engine_macros.svh"
module positional_list_engine
  import ple_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  mem_req_t         mem_req;
  logic [VAL_W-1:0] rdata;
  logic             res_load;
  result_t          res;
  ple_stat_t        stat;
  logic             out_free;

  assign out_free   = !result_valid || result_ready;
  assign item_ready = stat.idle;

  ple_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .item_take (item_valid && item_ready),
    .item      (item),
    .out_free  (out_free),
    .rdata     (rdata),
    .mem_req   (mem_req),
    .res_load  (res_load),
    .res       (res),
    .stat      (stat)
  );

  ple_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
      result       <= res;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  `PLE_ASSERT_NOW(a_load_free, clk, rst, res_load, out_free, "result overwritten while stalled")
  `PLE_ASSERT_NOW(a_count_cap, clk, rst, 1'b1, stat.count <= CNT_W'(CAPACITY), "count over capacity")
  `PLE_ASSERT_NEXT(a_busy_after_take, clk, rst, item_valid && item_ready, !item_ready, "ready while busy")
  `PLE_ASSERT_NEXT(a_count_match, clk, rst, res_load, result.entry_count == EC_W'(stat.count), "count mismatch")

endmodule
